@@ hdl/rpg_pkg.sv @@
`default_nettype none

package rpg_pkg;

	// Output quantization and series length
	localparam int ANGLE_BITS   = 32;
	localparam int APPROX_STEPS = 24;
	localparam int QS           = (ANGLE_BITS >= 32) ? 0 : 32 - ANGLE_BITS;
	localparam int K_W          = $clog2(APPROX_STEPS);

	localparam logic [31:0] YAW_MASK = ~((32'd1 << QS) - 32'd1);

	// Fixed point constants
	localparam logic [63:0] ONE_Q62 = 64'h4000_0000_0000_0000;
	localparam logic [63:0] PI_Q61  = 64'h6487_ED51_10B4_611A;
	localparam logic [63:0] HALF_64 = 64'h8000_0000_0000_0000;

	// Configuration port
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 48;

	localparam logic [CFG_IDX_W-1:0] REG_MODE        = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_VELOCITY    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_START_FRAME = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_END_FRAME   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_START_ANGLE = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_END_ANGLE   = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_FRAG_LEN    = 3'd6;

	// Modes
	localparam logic [2:0] MODE_LINEAR  = 3'd0;
	localparam logic [2:0] MODE_SIGMOID = 3'd1;
	localparam logic [2:0] MODE_COSINE  = 3'd2;
	localparam logic [2:0] MODE_FREE    = 3'd3;
	localparam logic [2:0] MODE_CLAMPED = 3'd4;

	// Sine series divisor (2k)(2k+1)
	function automatic logic [12:0] sin_coef(input logic [K_W-1:0] k);
		logic [12:0] k2;
		k2 = 13'({k, 1'b0});
		return 13'(k2 * (k2 + 13'd1));
	endfunction

endpackage

`default_nettype wire

@@ hdl/rpg_if.sv @@
`default_nettype none

// Frame channel
interface rpg_frame_if;
	logic        valid;
	logic        ready;
	logic [31:0] frame;

	modport source (output valid, output frame, input ready);
	modport sink   (input valid, input frame, output ready);
endinterface

// Angle channel
interface rpg_angle_if;
	logic        valid;
	logic        ready;
	logic [31:0] yaw;
	logic        span_zero;

	modport source (output valid, output yaw, output span_zero, input ready);
	modport sink   (input valid, input yaw, input span_zero, output ready);
endinterface

`default_nettype wire

@@ hdl/rpg_mul.sv @@
`default_nettype none

module rpg_mul
	import rpg_pkg::*;
(
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         start,
	input  wire logic [63:0]  a,
	input  wire logic [63:0]  b,
	output logic              busy,
	output logic              done,
	output logic [127:0]      prod
);

	logic [63:0]  a_q, b_q, pp_q;
	logic [127:0] acc_q;
	logic [2:0]   cnt_q, prev;
	logic         busy_q, done_q;
	logic [31:0]  a_h, b_h;
	logic [127:0] addend;

	// pick the 32-bit halves for this partial product
	always_comb begin
		a_h  = cnt_q[1] ? a_q[63:32] : a_q[31:0];
		b_h  = cnt_q[0] ? b_q[63:32] : b_q[31:0];
		prev = cnt_q - 3'd1;
		unique case (prev)
			3'd0:    addend = {64'd0, pp_q};
			3'd1,
			3'd2:    addend = {32'd0, pp_q, 32'd0};
			default: addend = {pp_q, 64'd0};
		endcase
	end

	// payload: operands, partial product, accumulator
	always_ff @(posedge clk) begin
		if (start) begin
			a_q   <= a;
			b_q   <= b;
			acc_q <= '0;
		end else if (busy_q) begin
			if (cnt_q != 3'd4)
				pp_q <= 64'(a_h) * 64'(b_h);
			if (cnt_q != 3'd0)
				acc_q <= acc_q + addend;
		end
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 3'd1;
			if (cnt_q == 3'd4) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	assign busy = busy_q;
	assign done = done_q;
	assign prod = acc_q;

endmodule

`default_nettype wire

@@ hdl/rpg_div.sv @@
`default_nettype none

module rpg_div
	import rpg_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic [63:0] n,
	input  wire logic [63:0] d,
	output logic             busy,
	output logic             done,
	output logic [63:0]      quo,
	output logic [63:0]      rem
);

	logic [63:0] n_q, d_q, rem_q;
	logic [5:0]  cnt_q;
	logic        busy_q, done_q;
	logic [64:0] trial, diff;
	logic        qbit;

	// one restoring step per cycle
	always_comb begin
		trial = {rem_q, n_q[63]};
		diff  = trial - {1'b0, d_q};
		qbit  = !diff[64];
	end

	always_ff @(posedge clk) begin
		if (start) begin
			n_q   <= n;
			d_q   <= d;
			rem_q <= '0;
		end else if (busy_q) begin
			n_q   <= {n_q[62:0], qbit};
			rem_q <= qbit ? diff[63:0] : trial[63:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 6'd1;
			if (cnt_q == 6'd63) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	assign busy = busy_q;
	assign done = done_q;
	assign quo  = n_q;
	assign rem  = rem_q;

endmodule

`default_nettype wire

@@ hdl/rotation_profile_generator.sv @@
// Rotation profile generator.
// frames (sink): one word per update, the transport frame. Accepted when
// valid and ready are high; ready is high only while the block is idle.
// angles (source): one word per update, yaw in 2^-32 turns and span_zero.
// The word is held until the receiver takes it; a stalled receiver keeps
// the block from accepting the next frame.
// Configuration: cfg_we/cfg_idx/cfg_data, one register per write; the user
// must write them only while idle, which the block itself does not enforce.
// All multiplies and divides run on one 32x32 multiplier (64x64 product)
// and one radix-2 divider, stepped by a sequencer:
//   linear, free:   one multiply per word
//   clamped linear: one multiply, after one divide unless the span is reversed
//   cosine:         23 series terms, multiply + divide
//   sigmoid:        series, six squarings, up to four further divides
//   zero span or unused mode: held yaw, no multiply or divide
// Reset restores the register defaults, clears the held yaw and drops
// any word in flight.
`default_nettype none

module rotation_profile_generator
	import rpg_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_idx,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	rpg_frame_if.sink                  frames,
	rpg_angle_if.source                angles
);

	// sequencer states
	localparam logic [4:0] ST_IDLE  = 5'd0;
	localparam logic [4:0] ST_GO    = 5'd1;
	localparam logic [4:0] ST_OUT   = 5'd2;
	localparam logic [4:0] ST_LIN   = 5'd3;
	localparam logic [4:0] ST_FREE  = 5'd4;
	localparam logic [4:0] ST_FRAC  = 5'd5;
	localparam logic [4:0] ST_PHI   = 5'd6;
	localparam logic [4:0] ST_P2    = 5'd7;
	localparam logic [4:0] ST_SMUL  = 5'd8;
	localparam logic [4:0] ST_SDIV  = 5'd9;
	localparam logic [4:0] ST_SSQ   = 5'd10;
	localparam logic [4:0] ST_SIP   = 5'd11;
	localparam logic [4:0] ST_SFR   = 5'd12;
	localparam logic [4:0] ST_SV    = 5'd13;
	localparam logic [4:0] ST_EMUL  = 5'd14;
	localparam logic [4:0] ST_EDIV  = 5'd15;
	localparam logic [4:0] ST_ESQ   = 5'd16;
	localparam logic [4:0] ST_W1    = 5'd17;
	localparam logic [4:0] ST_W2    = 5'd18;
	localparam logic [4:0] ST_BLEND = 5'd19;

	// configuration registers
	logic [2:0]  mode_q;
	logic [47:0] velocity_q;
	logic [31:0] start_frame_q, end_frame_q;
	logic [39:0] start_angle_q, end_angle_q;
	logic [16:0] frag_len_q;

	// sequencer state
	logic [4:0]     state_q;
	logic [31:0]    t_q;
	logic [K_W-1:0] k_q;
	logic [2:0]     sq_cnt_q;
	logic [2:0]     ip_q;
	logic [63:0]    term_q, sum_q, p2_q, den_q, w_q;
	logic           pos_q;
	logic [31:0]    yaw_q, held_q;
	logic           flag_q;

	// shared unit requests
	logic        mul_go_q, div_go_q;
	logic [63:0] mul_a_q, mul_b_q, div_n_q, div_d_q;
	logic        mul_busy, mul_done, div_busy, div_done;
	logic [127:0] mul_p;
	logic [63:0]  div_q, div_r;

	rpg_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_go_q),
		.a      (mul_a_q),
		.b      (mul_b_q),
		.busy   (mul_busy),
		.done   (mul_done),
		.prod   (mul_p)
	);

	rpg_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_go_q),
		.n      (div_n_q),
		.d      (div_d_q),
		.busy   (div_busy),
		.done   (div_done),
		.quo    (div_q),
		.rem    (div_r)
	);

	// operands derived from registers and the latched frame
	logic [63:0] vel64, d_lin64, delta64, sum_new, sum_clamp, sq_clamp, w_sig;
	logic [32:0] d_lin, span33;
	logic [40:0] delta41;
	logic [31:0] t_hi, t_c, diff32;
	logic [35:0] n36, d36, an36, ad36;
	logic        span_zero_c, sig_pos;
	logic [63:0] q62, q32, q33;
	logic [63:0] e_dq;

	always_comb begin
		vel64   = {{16{velocity_q[47]}}, velocity_q};
		d_lin   = {1'b0, t_q} - {1'b0, start_frame_q};
		d_lin64 = {{31{d_lin[32]}}, d_lin};
		delta41 = {end_angle_q[39], end_angle_q} - {start_angle_q[39], start_angle_q};
		delta64 = {{23{delta41[40]}}, delta41};
		span33  = {1'b0, end_frame_q} - {1'b0, start_frame_q};
		span_zero_c = (start_frame_q == end_frame_q);
		// clamp frame into the ramp
		t_hi   = (t_q > end_frame_q) ? end_frame_q : t_q;
		t_c    = (t_hi < start_frame_q) ? start_frame_q : t_hi;
		diff32 = t_c - start_frame_q;
		// sigmoid argument numerator and denominator
		n36  = {3'b0, t_q, 1'b0} - {4'b0, start_frame_q} - {4'b0, end_frame_q};
		d36  = {{2{span33[32]}}, span33, 1'b0};
		an36 = n36[35] ? -n36 : n36;
		ad36 = d36[35] ? -d36 : d36;
		sig_pos = (n36 == 36'd0) || (n36[35] == d36[35]);
		// product taps
		q62 = mul_p[125:62];
		q32 = mul_p[95:32];
		q33 = mul_p[96:33];
		// series accumulate: subtract on odd terms, saturating at zero
		if (k_q[0])
			sum_new = (div_q > sum_q) ? 64'd0 : sum_q - div_q;
		else
			sum_new = sum_q + div_q;
		sum_clamp = (sum_new > ONE_Q62) ? ONE_Q62 : sum_new;
		sq_clamp  = (q62 > ONE_Q62) ? ONE_Q62 : q62;
		e_dq      = (ONE_Q62 + q62) >> 30;
		w_sig     = {w_q[62:0], 1'b0} + div_q;
		if (!pos_q)
			w_sig = 64'h1_0000_0000 - w_sig;
	end

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q        <= MODE_LINEAR;
			velocity_q    <= 48'd162890612;
			start_frame_q <= 32'd0;
			end_frame_q   <= 32'd48000;
			start_angle_q <= 40'hFF_C000_0000;
			end_angle_q   <= 40'h00_4000_0000;
			frag_len_q    <= 17'd64;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_MODE:        mode_q        <= cfg_data[2:0];
				REG_VELOCITY:    velocity_q    <= cfg_data[47:0];
				REG_START_FRAME: start_frame_q <= cfg_data[31:0];
				REG_END_FRAME:   end_frame_q   <= cfg_data[31:0];
				REG_START_ANGLE: start_angle_q <= cfg_data[39:0];
				REG_END_ANGLE:   end_angle_q   <= cfg_data[39:0];
				REG_FRAG_LEN:    frag_len_q    <= cfg_data[16:0];
				default: ;
			endcase
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			held_q   <= 32'd0;
			mul_go_q <= 1'b0;
			div_go_q <= 1'b0;
			k_q      <= '0;
			sq_cnt_q <= '0;
			flag_q   <= 1'b0;
		end else begin
			mul_go_q <= 1'b0;
			div_go_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (frames.valid) begin
						t_q     <= frames.frame;
						state_q <= ST_GO;
					end
				end
				ST_GO: begin
					flag_q <= 1'b0;
					unique case (mode_q)
						MODE_LINEAR: begin
							mul_go_q <= 1'b1;
							mul_a_q  <= vel64;
							mul_b_q  <= d_lin64;
							state_q  <= ST_LIN;
						end
						MODE_FREE: begin
							mul_go_q <= 1'b1;
							mul_a_q  <= vel64;
							mul_b_q  <= {47'd0, frag_len_q};
							state_q  <= ST_FREE;
						end
						MODE_SIGMOID, MODE_COSINE, MODE_CLAMPED: begin
							if (span_zero_c) begin
								yaw_q   <= held_q;
								flag_q  <= 1'b1;
								state_q <= ST_OUT;
							end else if (mode_q == MODE_SIGMOID) begin
								div_go_q <= 1'b1;
								div_n_q  <= {28'd0, an36};
								div_d_q  <= {28'd0, ad36};
								den_q    <= {28'd0, ad36};
								pos_q    <= sig_pos;
								state_q  <= ST_SIP;
							end else if (span33[32]) begin
								// reversed span: weight zero
								mul_go_q <= 1'b1;
								mul_a_q  <= delta64;
								mul_b_q  <= 64'd0;
								state_q  <= ST_BLEND;
							end else begin
								div_go_q <= 1'b1;
								div_n_q  <= {diff32, 32'd0};
								div_d_q  <= {32'd0, span33[31:0]};
								state_q  <= ST_FRAC;
							end
						end
						default: begin
							yaw_q   <= held_q;
							state_q <= ST_OUT;
						end
					endcase
				end
				ST_LIN: begin
					if (mul_done) begin
						yaw_q   <= mul_p[47:16];
						held_q  <= mul_p[47:16];
						state_q <= ST_OUT;
					end
				end
				ST_FREE: begin
					if (mul_done) begin
						yaw_q   <= held_q + mul_p[47:16];
						held_q  <= held_q + mul_p[47:16];
						state_q <= ST_OUT;
					end
				end
				ST_FRAC: begin
					if (div_done) begin
						mul_go_q <= 1'b1;
						if (mode_q == MODE_CLAMPED) begin
							mul_a_q <= delta64;
							mul_b_q <= div_q;
							state_q <= ST_BLEND;
						end else begin
							mul_a_q <= PI_Q61;
							mul_b_q <= div_q;
							state_q <= ST_PHI;
						end
					end
				end
				// cosine: sine series on phi
				ST_PHI: begin
					if (mul_done) begin
						term_q   <= q32;
						sum_q    <= q32;
						mul_go_q <= 1'b1;
						mul_a_q  <= q32;
						mul_b_q  <= q32;
						state_q  <= ST_P2;
					end
				end
				ST_P2: begin
					if (mul_done) begin
						p2_q     <= q62;
						k_q      <= K_W'(1);
						mul_go_q <= 1'b1;
						mul_a_q  <= term_q;
						mul_b_q  <= q62;
						state_q  <= ST_SMUL;
					end
				end
				ST_SMUL: begin
					if (mul_done) begin
						div_go_q <= 1'b1;
						div_n_q  <= q62;
						div_d_q  <= {51'd0, sin_coef(k_q)};
						state_q  <= ST_SDIV;
					end
				end
				ST_SDIV: begin
					if (div_done) begin
						term_q   <= div_q;
						sum_q    <= sum_new;
						mul_go_q <= 1'b1;
						if (k_q == K_W'(APPROX_STEPS - 1)) begin
							mul_a_q <= sum_new;
							mul_b_q <= sum_new;
							state_q <= ST_SSQ;
						end else begin
							k_q     <= k_q + K_W'(1);
							mul_a_q <= div_q;
							mul_b_q <= p2_q;
							state_q <= ST_SMUL;
						end
					end
				end
				ST_SSQ: begin
					if (mul_done) begin
						mul_go_q <= 1'b1;
						mul_a_q  <= delta64;
						mul_b_q  <= sq_clamp >> 30;
						state_q  <= ST_BLEND;
					end
				end
				// sigmoid: integer part, then fraction of u
				ST_SIP: begin
					if (div_done) begin
						if (div_q >= 64'd5) begin
							mul_go_q <= 1'b1;
							mul_a_q  <= PI_Q61;
							mul_b_q  <= 64'd5 << 29;
							state_q  <= ST_SV;
						end else begin
							ip_q     <= div_q[2:0];
							div_go_q <= 1'b1;
							div_n_q  <= {div_r[34:0], 29'd0};
							div_d_q  <= den_q;
							state_q  <= ST_SFR;
						end
					end
				end
				ST_SFR: begin
					if (div_done) begin
						mul_go_q <= 1'b1;
						mul_a_q  <= PI_Q61;
						mul_b_q  <= {32'd0, ip_q, 29'd0} + div_q;
						state_q  <= ST_SV;
					end
				end
				ST_SV: begin
					if (mul_done) begin
						p2_q     <= q33;
						term_q   <= ONE_Q62;
						sum_q    <= ONE_Q62;
						k_q      <= K_W'(1);
						mul_go_q <= 1'b1;
						mul_a_q  <= ONE_Q62;
						mul_b_q  <= q33;
						state_q  <= ST_EMUL;
					end
				end
				ST_EMUL: begin
					if (mul_done) begin
						div_go_q <= 1'b1;
						div_n_q  <= q62;
						div_d_q  <= 64'(k_q);
						state_q  <= ST_EDIV;
					end
				end
				ST_EDIV: begin
					if (div_done) begin
						term_q   <= div_q;
						sum_q    <= sum_new;
						mul_go_q <= 1'b1;
						if (k_q == K_W'(APPROX_STEPS - 1)) begin
							sq_cnt_q <= 3'd0;
							mul_a_q  <= sum_clamp;
							mul_b_q  <= sum_clamp;
							state_q  <= ST_ESQ;
						end else begin
							k_q     <= k_q + K_W'(1);
							mul_a_q <= div_q;
							mul_b_q <= p2_q;
							state_q <= ST_EMUL;
						end
					end
				end
				// six squarings give e^-|z|
				ST_ESQ: begin
					if (mul_done) begin
						if (sq_cnt_q == 3'd5) begin
							den_q    <= e_dq;
							div_go_q <= 1'b1;
							div_n_q  <= HALF_64;
							div_d_q  <= e_dq;
							state_q  <= ST_W1;
						end else begin
							sq_cnt_q <= sq_cnt_q + 3'd1;
							mul_go_q <= 1'b1;
							mul_a_q  <= q62;
							mul_b_q  <= q62;
						end
					end
				end
				ST_W1: begin
					if (div_done) begin
						w_q      <= div_q;
						div_go_q <= 1'b1;
						div_n_q  <= {div_r[62:0], 1'b0};
						div_d_q  <= den_q;
						state_q  <= ST_W2;
					end
				end
				ST_W2: begin
					if (div_done) begin
						mul_go_q <= 1'b1;
						mul_a_q  <= delta64;
						mul_b_q  <= w_sig;
						state_q  <= ST_BLEND;
					end
				end
				ST_BLEND: begin
					if (mul_done) begin
						yaw_q   <= start_angle_q[31:0] + mul_p[63:32];
						held_q  <= start_angle_q[31:0] + mul_p[63:32];
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (angles.ready)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign frames.ready     = (state_q == ST_IDLE);
	assign angles.valid     = (state_q == ST_OUT);
	assign angles.yaw       = yaw_q & YAW_MASK;
	assign angles.span_zero = flag_q;

`ifndef NO_ASSERTIONS
	// a frame is taken only with both shared units at rest
	a_accept_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(frames.valid && frames.ready) |-> (!mul_busy && !div_busy))
		else $error("frame accepted while a unit is busy");

	// the sequencer never runs both units at once
	a_one_unit: assert property (@(posedge clk) disable iff (!arst_n)
		!(mul_busy && div_busy))
		else $error("multiplier and divider busy together");

	// span_zero only for a ramp mode with an empty span
	a_flag_mode: assert property (@(posedge clk) disable iff (!arst_n)
		(angles.valid && angles.span_zero) |->
		((mode_q == MODE_SIGMOID || mode_q == MODE_COSINE || mode_q == MODE_CLAMPED)
		 && start_frame_q == end_frame_q))
		else $error("span_zero raised outside a zero-span ramp");

	// a delivered word returns the block to idle
	a_back_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(angles.valid && angles.ready) |=> frames.ready)
		else $error("not ready after delivering a word");
`endif

endmodule

`default_nettype wire

@@ dv/rpg_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none

module rpg_checker
	import rpg_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_idx,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	rpg_frame_if                       frames,
	rpg_angle_if                       angles,
	output int                         errors,
	output int                         pending,
	output int                         checked
);

	typedef logic [63:0] u64_t;

	typedef struct packed {
		logic [31:0] yaw;
		logic        span_zero;
	} angle_word_t;

	// Shadow copy of the registers and the held yaw
	logic [2:0]  mode_r;
	logic [47:0] vel_r;
	logic [31:0] t0_r;
	logic [31:0] t1_r;
	logic [39:0] a0_r;
	logic [39:0] a1_r;
	logic [16:0] frag_r;
	logic [31:0] held_yaw;

	angle_word_t angle_q[$];

	assign pending = angle_q.size();

	// Bits s..s+63 of the full 128-bit product
	function automatic u64_t mul_shr(input u64_t a, input u64_t b, input int s);
		logic [127:0] p;
		p = {64'b0, a} * {64'b0, b};
		p = p >> s;
		return p[63:0];
	endfunction

	function automatic u64_t sine_q62(input u64_t phi);
		u64_t p2, term, sum;
		p2 = mul_shr(phi, phi, 62);
		term = phi;
		sum = phi;
		for (int k = 1; k < APPROX_STEPS; k++) begin
			term = mul_shr(term, p2, 62) / u64_t'((2 * k) * (2 * k + 1));
			if (k % 2 == 1)
				sum = (term > sum) ? 64'd0 : sum - term;
			else
				sum = sum + term;
		end
		return sum;
	endfunction

	// e^-64v as the 64th power of a short series at v
	function automatic u64_t exp_neg_q62(input u64_t v);
		u64_t term, sum;
		term = ONE_Q62;
		sum = ONE_Q62;
		for (int k = 1; k < APPROX_STEPS; k++) begin
			term = mul_shr(term, v, 62) / u64_t'(k);
			if (k % 2 == 1)
				sum = (term > sum) ? 64'd0 : sum - term;
			else
				sum = sum + term;
		end
		if (sum > ONE_Q62)
			sum = ONE_Q62;
		for (int k = 0; k < 6; k++)
			sum = mul_shr(sum, sum, 62);
		return sum;
	endfunction

	function automatic u64_t ramp_q32(input longint t, input longint t0,
			input longint t1);
		longint tc, span;
		span = t1 - t0;
		tc = (t > t1) ? t1 : t;
		if (tc < t0)
			tc = t0;
		if (span <= 0)
			return 64'd0;
		return (u64_t'(tc - t0) << 32) / u64_t'(span);
	endfunction

	function automatic u64_t logistic_q32(input longint t, input longint t0,
			input longint t1);
		longint numer, den;
		u64_t an, ad, ip, u, e, dq, h, w;
		logic pos;
		numer = 2 * t - t0 - t1;
		den = 2 * (t1 - t0);
		an = u64_t'(numer < 0 ? -numer : numer);
		ad = u64_t'(den < 0 ? -den : den);
		ip = an / ad;
		pos = (numer == 0) || ((numer > 0) == (den > 0));
		// argument saturates at five spans
		if (ip >= 5)
			u = u64_t'(5) << 29;
		else
			u = (ip << 29) + (((an % ad) << 29) / ad);
		e = exp_neg_q62(mul_shr(PI_Q61, u, 33));
		dq = (ONE_Q62 + e) >> 30;
		h = HALF_64;
		w = 2 * (h / dq) + (2 * (h % dq)) / dq;
		return pos ? w : (u64_t'(1) << 32) - w;
	endfunction

	function automatic logic [31:0] blend_angle(input u64_t w);
		u64_t a0, delta, p, s;
		a0 = {{24{a0_r[39]}}, a0_r};
		delta = {{24{a1_r[39]}}, a1_r} - a0;
		p = delta * w;
		s = a0 + (p >> 32);
		return s[31:0];
	endfunction

	function automatic angle_word_t next_angle(input logic [31:0] frame);
		longint t, t0, t1;
		u64_t vel, prod, w, s, sq;
		logic [31:0] yaw;
		angle_word_t r;
		t = longint'({32'b0, frame});
		t0 = longint'({32'b0, t0_r});
		t1 = longint'({32'b0, t1_r});
		vel = {{16{vel_r[47]}}, vel_r};
		yaw = held_yaw;
		r.span_zero = 1'b0;
		case (mode_r)
			MODE_LINEAR: begin
				prod = vel * u64_t'(t - t0);
				yaw = prod[47:16];
			end
			MODE_FREE: begin
				prod = vel * {47'b0, frag_r};
				yaw = held_yaw + prod[47:16];
			end
			MODE_SIGMOID, MODE_COSINE, MODE_CLAMPED: begin
				if (t1 == t0) begin
					// zero span holds the yaw
					r.span_zero = 1'b1;
				end else begin
					if (mode_r == MODE_CLAMPED) begin
						w = ramp_q32(t, t0, t1);
					end else if (mode_r == MODE_COSINE) begin
						s = sine_q62(mul_shr(PI_Q61, ramp_q32(t, t0, t1), 32));
						sq = mul_shr(s, s, 62);
						if (sq > ONE_Q62)
							sq = ONE_Q62;
						w = sq >> 30;
					end else begin
						w = logistic_q32(t, t0, t1);
					end
					yaw = blend_angle(w);
				end
			end
			default: ;
		endcase
		held_yaw = yaw;
		r.yaw = yaw & YAW_MASK;
		return r;
	endfunction

	task automatic report(input string what, input logic [63:0] got,
			input logic [63:0] want);
		$display("[%0t] mismatch on %s: got %h, expected %h", $time, what, got, want);
		errors++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		angle_word_t exp_w;
		if (!arst_n) begin
			mode_r   = MODE_LINEAR;
			vel_r    = 48'd162890612;
			t0_r     = 32'd0;
			t1_r     = 32'd48000;
			a0_r     = 40'hFF_C000_0000;
			a1_r     = 40'h00_4000_0000;
			frag_r   = 17'd64;
			held_yaw = 32'd0;
			errors   = 0;
			checked  = 0;
			angle_q.delete();
		end else begin
			// register writes
			if (cfg_we) begin
				case (cfg_idx)
					REG_MODE:        mode_r = cfg_data[2:0];
					REG_VELOCITY:    vel_r  = cfg_data[47:0];
					REG_START_FRAME: t0_r   = cfg_data[31:0];
					REG_END_FRAME:   t1_r   = cfg_data[31:0];
					REG_START_ANGLE: a0_r   = cfg_data[39:0];
					REG_END_ANGLE:   a1_r   = cfg_data[39:0];
					REG_FRAG_LEN:    frag_r = cfg_data[16:0];
					default: ;
				endcase
			end
			// accepted frame word
			if (frames.valid && frames.ready)
				angle_q.push_back(next_angle(frames.frame));
			// accepted angle word
			if (angles.valid && angles.ready) begin
				if (angle_q.size() == 0) begin
					report("unexpected word", {32'b0, angles.yaw}, 64'd0);
				end else begin
					exp_w = angle_q.pop_front();
					checked++;
					if (angles.yaw !== exp_w.yaw)
						report("yaw", {32'b0, angles.yaw}, {32'b0, exp_w.yaw});
					if (angles.span_zero !== exp_w.span_zero)
						report("span_zero", {63'b0, angles.span_zero},
							{63'b0, exp_w.span_zero});
				end
			end
		end
	end

endmodule

`default_nettype wire

@@ dv/rotation_profile_generator_tb.sv @@
`timescale 1ns / 1ps
`default_nettype none

module rotation_profile_generator_tb;
	import rpg_pkg::*;

	localparam int N_ITEMS   = 1350;
	localparam int LIMIT     = 20000000;
	localparam int HOLD_LEN  = 3000;

	localparam logic [2:0] MODE_SPARE_LO = 3'd5;
	localparam logic [2:0] MODE_SPARE_HI = 3'd7;
	localparam logic [CFG_IDX_W-1:0] REG_NONE = 3'd7;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_idx;
	logic [CFG_DATA_W-1:0] cfg_data;

	int errors, pending, checked;
	int cycles;
	int items;
	int snd_idle, rcv_idle;
	int hold_left;
	int hold_req, hold_ack;
	logic [2:0] cur_mode;
	logic [31:0] cur_t0, cur_t1;
	int mode_items[8];

	rpg_frame_if frames ();
	rpg_angle_if angles ();

	rotation_profile_generator u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data),
		.frames   (frames),
		.angles   (angles)
	);

	rpg_checker u_checker (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data),
		.frames   (frames),
		.angles   (angles),
		.errors   (errors),
		.pending  (pending),
		.checked  (checked)
	);

	always begin
		clk = 1'b1;
		#6;
		clk = 1'b0;
		#6;
	end

	// Watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT) begin
			$display("timeout after %0d cycles, %0d words still due", cycles, pending);
			$display("** rotation_profile_generator: FAILED **");
			$finish;
		end
	end

	// Receiver: random stalls plus one long hold-off on request
	always @(negedge clk) begin
		if (hold_left > 0) begin
			angles.ready <= 1'b0;
			hold_left--;
		end else if (hold_ack != hold_req) begin
			hold_ack = hold_req;
			hold_left = HOLD_LEN;
			angles.ready <= 1'b0;
		end else begin
			angles.ready <= ($urandom_range(99) >= rcv_idle);
		end
	end

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_we   <= 1'b1;
		cfg_idx  <= idx;
		cfg_data <= data;
		if (idx == REG_MODE)
			cur_mode = data[2:0];
		if (idx == REG_START_FRAME)
			cur_t0 = data[31:0];
		if (idx == REG_END_FRAME)
			cur_t1 = data[31:0];
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic send_frame(input logic [31:0] f);
		@(negedge clk);
		while ($urandom_range(99) < snd_idle) begin
			frames.valid <= 1'b0;
			@(negedge clk);
		end
		frames.valid <= 1'b1;
		frames.frame <= f;
		do @(posedge clk); while (!frames.ready);
		items++;
		mode_items[cur_mode]++;
		// idle pattern follows progress
		if (items == N_ITEMS / 3) begin
			snd_idle = 47;
			rcv_idle = 13;
		end else if (items == 2 * N_ITEMS / 3) begin
			snd_idle = 0;
			rcv_idle = 0;
		end
	endtask

	// Stop offering and let every outstanding word come back
	task automatic drain();
		@(negedge clk);
		frames.valid <= 1'b0;
		while (pending != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	function automatic logic [47:0] rand48();
		case ($urandom_range(9))
			0: return 48'h7FFF_FFFF_FFFF;
			1: return 48'h8000_0000_0000;
			2: return 48'($urandom_range(65535));
			default: return {$urandom, $urandom};
		endcase
	endfunction

	function automatic logic [39:0] rand40();
		case ($urandom_range(7))
			0: return 40'h7F_FFFF_FFFF;
			1: return 40'h80_0000_0000;
			default: return {$urandom, $urandom};
		endcase
	endfunction

	// Frames mostly around the current ramp
	function automatic logic [31:0] pick_frame();
		longint lo, hi, len;
		lo = (cur_t0 < cur_t1) ? cur_t0 : cur_t1;
		hi = (cur_t0 < cur_t1) ? cur_t1 : cur_t0;
		len = hi - lo;
		case ($urandom_range(9))
			0: return $urandom;
			1: return cur_t0;
			2: return cur_t1;
			default: return 32'(lo - len / 4 + ({$urandom, $urandom} % (len + len / 2 + 1)));
		endcase
	endfunction

	task automatic random_block();
		int r, n;
		logic [2:0] m;
		logic [31:0] t0, span;
		bit slow;
		r = $urandom_range(99);
		if (r < 10)
			m = MODE_SIGMOID;
		else if (r < 20)
			m = MODE_COSINE;
		else if (r < 42)
			m = MODE_CLAMPED;
		else if (r < 66)
			m = MODE_LINEAR;
		else if (r < 94)
			m = MODE_FREE;
		else
			m = 3'($urandom_range(MODE_SPARE_LO, MODE_SPARE_HI));
		slow = (m == MODE_SIGMOID) || (m == MODE_COSINE);
		drain();
		write_reg(REG_MODE, 48'(m));
		write_reg(REG_VELOCITY, rand48());
		t0 = ($urandom_range(3) == 0) ? $urandom : 32'($urandom_range(1 << 20));
		case ($urandom_range(9))
			0: span = 32'd0;
			1: span = 32'(-$urandom_range(1, 5000));
			2: span = $urandom;
			default: span = 32'($urandom_range(1, 1 << 16));
		endcase
		write_reg(REG_START_FRAME, 48'(t0));
		write_reg(REG_END_FRAME, 48'(t0 + span));
		write_reg(REG_START_ANGLE, 48'(rand40()));
		write_reg(REG_END_ANGLE, 48'(rand40()));
		write_reg(REG_FRAG_LEN, ($urandom_range(7) == 0) ? 48'($urandom_range(131071))
			: 48'($urandom_range(1, 65536)));
		n = slow ? $urandom_range(2, 5) : $urandom_range(10, 40);
		repeat (n)
			send_frame(pick_frame());
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_idx = REG_MODE;
		cfg_data = '0;
		frames.valid = 1'b0;
		frames.frame = '0;
		items = 0;
		snd_idle = 13;
		rcv_idle = 47;
		cur_mode = MODE_LINEAR;
		cur_t0 = 32'd0;
		cur_t1 = 32'd48000;
		repeat (11) @(negedge clk);
		arst_n = 1'b1;

		// Defaults: linear from frame zero, then velocity extremes
		send_frame(32'd0);
		send_frame(32'd48000);
		send_frame(32'hFFFF_FFFF);
		drain();
		write_reg(REG_VELOCITY, 48'h7FFF_FFFF_FFFF);
		send_frame(32'hFFFF_FFFF);
		drain();
		write_reg(REG_VELOCITY, 48'h8000_0000_0000);
		send_frame(32'd12345);

		// Free accumulation, zero and oversized fragments
		drain();
		write_reg(REG_MODE, 48'(MODE_FREE));
		write_reg(REG_FRAG_LEN, 48'd0);
		send_frame(32'd1);
		drain();
		write_reg(REG_FRAG_LEN, 48'h1FFFF);
		send_frame(32'd2);
		drain();
		write_reg(REG_FRAG_LEN, 48'd65536);
		send_frame(32'd3);

		// Clamped ramp between the angle extremes
		drain();
		write_reg(REG_MODE, 48'(MODE_CLAMPED));
		write_reg(REG_START_FRAME, 48'd1000);
		write_reg(REG_END_FRAME, 48'd2000);
		write_reg(REG_START_ANGLE, 48'h00_80_0000_0000);
		write_reg(REG_END_ANGLE, 48'h00_7F_FFFF_FFFF);
		send_frame(32'd0);
		send_frame(32'd1500);
		send_frame(32'd2000);
		send_frame(32'hFFFF_FFFF);
		// reversed span, then zero span
		drain();
		write_reg(REG_END_FRAME, 48'd500);
		send_frame(32'd700);
		drain();
		write_reg(REG_END_FRAME, 48'd1000);
		send_frame(32'd1000);

		// Cosine ramp
		drain();
		write_reg(REG_MODE, 48'(MODE_COSINE));
		write_reg(REG_END_FRAME, 48'd2000);
		send_frame(32'd1000);
		send_frame(32'd1500);
		send_frame(32'd1999);

		// Sigmoid: far below, center, saturated above, reversed span
		drain();
		write_reg(REG_MODE, 48'(MODE_SIGMOID));
		send_frame(32'd0);
		send_frame(32'd1500);
		send_frame(32'hFFFF_FFFF);
		drain();
		write_reg(REG_END_FRAME, 48'd500);
		send_frame(32'd600);

		// Unused modes and an unknown register index
		drain();
		write_reg(REG_MODE, 48'(MODE_SPARE_LO));
		write_reg(REG_NONE, 48'hFFFF_FFFF_FFFF);
		send_frame(32'd1);
		drain();
		write_reg(REG_MODE, 48'(MODE_SPARE_HI));
		send_frame(32'd2);

		// Long receiver hold-off while linear frames keep being offered
		drain();
		write_reg(REG_MODE, 48'(MODE_LINEAR));
		hold_req++;
		repeat (30)
			send_frame($urandom);

		while (items < N_ITEMS)
			random_block();

		drain();
		repeat (20) @(posedge clk);
		$display("%0d frames sent, %0d angle words checked in %0d cycles", items, checked,
			cycles);
		$display("per mode: linear %0d sigmoid %0d cosine %0d free %0d clamped %0d other %0d",
			mode_items[MODE_LINEAR], mode_items[MODE_SIGMOID], mode_items[MODE_COSINE],
			mode_items[MODE_FREE], mode_items[MODE_CLAMPED],
			mode_items[5] + mode_items[6] + mode_items[7]);
		if (errors == 0)
			$display("** rotation_profile_generator: PASSED **");
		else
			$display("** rotation_profile_generator: FAILED **");
		$finish;
	end

endmodule

`default_nettype wire

@@ files.f @@
hdl/rpg_pkg.sv
hdl/rpg_if.sv
hdl/rpg_mul.sv
hdl/rpg_div.sv
hdl/rotation_profile_generator.sv
dv/rpg_checker.sv
dv/rotation_profile_generator_tb.sv
